[rtl/sliding_or_cumulative_average_core_defines.svh]
// assertion macros for the moving average core checker
// expects signals named clk and rst in the scope where a macro is used
`ifndef SLIDING_OR_CUMULATIVE_AVERAGE_CORE_DEFINES_SVH
`define SLIDING_OR_CUMULATIVE_AVERAGE_CORE_DEFINES_SVH

// checked only outside reset
`define SOCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define SOCA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/soca_pkg.sv]
// shared types and constants for the moving average core
// used by soca_ctrl, soca_datapath and the top level; no dependencies
package soca_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int COUNT_W     = 32;
  localparam int CFG_DATA_W  = 9;
  localparam int CFG_INDEX_W = 1;
  localparam int SIZE_W      = 17;

  localparam logic OP_PUT   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic MODE_WINDOW     = 1'b0;
  localparam logic MODE_CUMULATIVE = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_AVERAGE_MODE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SIZE  = 1'd1;

  localparam logic [CFG_DATA_W-1:0] WINDOW_SIZE_RESET = 9'd256;

  typedef struct packed {
    logic capture;
    logic clear;
    logic win_prep;
    logic win_sum;
    logic cum_step;
    logic div_init;
    logic div_step;
    logic div_done;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic op_clear;
    logic mode_window;
    logic cum_overflow;
    logic div_last;
  } status_t;

endpackage

[rtl/sliding_or_cumulative_average_core.sv]
// top level of the moving average core
// depends on soca_pkg, soca_ctrl and soca_datapath
//
// Moving average of unsigned 16-bit samples, one result transaction per input
// transaction: the floor of the running sum over the sample count, either over
// a sliding window of window_size samples (average_mode 0) or over all samples
// since the last clear (average_mode 1). In cumulative mode a sample that would
// wrap the sum or the count is dropped, the previous average is returned and
// overflow_hold is set. Items are handled one at a time. A put in window mode
// updates the window store, then the sum, and then runs the radix-2 divider,
// which retires one quotient bit per cycle; in cumulative mode a put goes from
// the sum update to the divider, and a clear or a rejected sample skips it.
// The result sits in an output register, so the next transaction is taken
// while a result is still stalled. Configuration writes are always ready and
// belong in idle periods only; the window store needs no clearing after reset.
module sliding_or_cumulative_average_core #(
  parameter int WINDOW_DEPTH = 256,
  parameter int SUM_WIDTH    = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                operation,
  input  logic [soca_pkg::SAMPLE_W-1:0]       sample_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [soca_pkg::SAMPLE_W-1:0]       average_value,
  output logic                                overflow_hold,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [soca_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [soca_pkg::CFG_DATA_W-1:0]     cfg_data
);

  soca_pkg::cmd_t    cmd;
  soca_pkg::status_t status;

  assign cfg_ready = 1'b1;

  soca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  soca_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SUM_WIDTH    (SUM_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .operation     (operation),
    .sample_value  (sample_value),
    .cfg_write     (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .average_value (average_value),
    .overflow_hold (overflow_hold)
  );

endmodule

[rtl/soca_ctrl.sv]
// sequencer for the moving average core
// depends on soca_pkg for the command and status structs
module soca_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  soca_pkg::status_t  status,
  output soca_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WSUM,
    ST_DIV_INIT,
    ST_DIV_RUN,
    ST_DIV_DONE,
    ST_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.op_clear) begin
          cmd.clear  = 1'b1;
          state_next = ST_FINISH;
        end else if (status.mode_window) begin
          cmd.win_prep = 1'b1;
          state_next   = ST_WSUM;
        end else begin
          cmd.cum_step = 1'b1;
          // rejected sample keeps the previous average
          state_next   = status.cum_overflow ? ST_FINISH : ST_DIV_INIT;
        end
      end
      ST_WSUM: begin
        cmd.win_sum = 1'b1;
        state_next  = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_DIV_DONE;
        end
      end
      ST_DIV_DONE: begin
        cmd.div_done = 1'b1;
        state_next   = ST_FINISH;
      end
      ST_FINISH: begin
        // wait for the output register to free up
        if (!out_valid || !out_stall) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/soca_datapath.sv]
// datapath for the moving average core: window store, running sum and count,
// radix-2 restoring divider, configuration registers; depends on soca_pkg
module soca_datapath #(
  parameter int WINDOW_DEPTH = 256,
  parameter int SUM_WIDTH    = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  soca_pkg::cmd_t                      cmd,
  output soca_pkg::status_t                   status,
  input  logic                                operation,
  input  logic [soca_pkg::SAMPLE_W-1:0]       sample_value,
  input  logic                                cfg_write,
  input  logic [soca_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [soca_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic [soca_pkg::SAMPLE_W-1:0]       average_value,
  output logic                                overflow_hold
);

  localparam int AW     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW     = $clog2(SUM_WIDTH);
  localparam int SW     = SUM_WIDTH;
  localparam int SMP_W  = soca_pkg::SAMPLE_W;
  localparam int CNT_W  = soca_pkg::COUNT_W;
  localparam int SZ_W   = soca_pkg::SIZE_W;
  localparam logic [SZ_W-1:0] DEPTH_S = SZ_W'(WINDOW_DEPTH);

  // configuration
  logic                               average_mode;
  logic [soca_pkg::CFG_DATA_W-1:0]    window_size;

  // running state
  logic [AW-1:0]     pos;
  logic [CNT_W-1:0]  count;
  logic [SW-1:0]     sum;
  logic [SMP_W-1:0]  last_average;

  // per-transaction registers
  logic              op_reg;
  logic [SMP_W-1:0]  sample;
  logic              hold_flag;
  logic              was_full;
  logic [SMP_W-1:0]  oldest;

  // divider
  logic [SW-1:0]     div_q;
  logic [CNT_W-1:0]  div_r;
  logic [CW-1:0]     div_cnt;

  logic [SMP_W-1:0]  store [WINDOW_DEPTH];

  logic [SZ_W-1:0]   ws_ext;
  logic [SZ_W-1:0]   size;
  logic [SZ_W-1:0]   pos_ext;
  logic [SZ_W-1:0]   pos_eff_ext;
  logic [AW-1:0]     pos_eff;
  logic [SZ_W-1:0]   pos_inc;
  logic [SZ_W-1:0]   pos_wrap;
  logic [CNT_W-1:0]  size32;
  logic [CNT_W-1:0]  cnt_clamp;
  logic              full_now;
  logic [SW:0]       cum_sum;
  logic              cum_overflow;
  logic [SW-1:0]     win_sum;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    div_diff;
  logic              div_ge;
  logic [SMP_W-1:0]  avg_div;

  // effective window size saturates to 1..WINDOW_DEPTH
  assign ws_ext = {{(SZ_W-soca_pkg::CFG_DATA_W){1'b0}}, window_size};
  always_comb begin
    if (ws_ext == '0) begin
      size = SZ_W'(1);
    end else if (ws_ext > DEPTH_S) begin
      size = DEPTH_S;
    end else begin
      size = ws_ext;
    end
  end

  // position restarts at zero if the window shrank under it
  assign pos_ext     = {{(SZ_W-AW){1'b0}}, pos};
  assign pos_eff_ext = (pos_ext >= size) ? '0 : pos_ext;
  assign pos_eff     = pos_eff_ext[AW-1:0];
  assign pos_inc     = pos_eff_ext + SZ_W'(1);
  assign pos_wrap    = (pos_inc >= size) ? '0 : pos_inc;

  assign size32    = {{(CNT_W-SZ_W){1'b0}}, size};
  assign cnt_clamp = (count > size32) ? size32 : count;
  assign full_now  = (cnt_clamp >= size32);

  assign cum_sum      = {1'b0, sum} + (SW+1)'(sample);
  assign cum_overflow = cum_sum[SW] | (count == '1);

  assign win_sum = sum + SW'(sample) - (was_full ? SW'(oldest) : '0);

  assign shifted  = {div_r, div_q[SW-1]};
  assign div_diff = shifted - {1'b0, count};
  assign div_ge   = (shifted >= {1'b0, count});

  always_comb begin
    if (count == '0) begin
      avg_div = '0;
    end else if (|div_q[SW-1:SMP_W]) begin
      avg_div = '1;
    end else begin
      avg_div = div_q[SMP_W-1:0];
    end
  end

  assign status.op_clear     = (op_reg == soca_pkg::OP_CLEAR);
  assign status.mode_window  = (average_mode == soca_pkg::MODE_WINDOW);
  assign status.cum_overflow = cum_overflow;
  assign status.div_last     = (div_cnt == CW'(SW-1));

  // window store: read of the overwritten entry and write of the new sample
  always_ff @(posedge clk) begin
    if (cmd.win_prep) begin
      oldest         <= store[pos_eff];
      store[pos_eff] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      average_mode <= soca_pkg::MODE_CUMULATIVE;
      window_size  <= soca_pkg::WINDOW_SIZE_RESET;
      pos          <= '0;
      count        <= '0;
      sum          <= '0;
      last_average <= '0;
      hold_flag    <= 1'b0;
      div_cnt      <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          soca_pkg::REG_AVERAGE_MODE: average_mode <= cfg_data[0];
          soca_pkg::REG_WINDOW_SIZE:  window_size  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.capture) begin
        hold_flag <= 1'b0;
      end
      if (cmd.clear) begin
        pos          <= '0;
        count        <= '0;
        sum          <= '0;
        last_average <= '0;
      end
      if (cmd.win_prep) begin
        pos   <= pos_wrap[AW-1:0];
        count <= full_now ? cnt_clamp : cnt_clamp + CNT_W'(1);
      end
      if (cmd.win_sum) begin
        sum <= win_sum;
      end
      if (cmd.cum_step) begin
        hold_flag <= cum_overflow;
        if (!cum_overflow) begin
          sum   <= cum_sum[SW-1:0];
          count <= count + CNT_W'(1);
        end
      end
      if (cmd.div_init) begin
        div_cnt <= '0;
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt + CW'(1);
      end
      if (cmd.div_done) begin
        last_average <= avg_div;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_reg <= operation;
      sample <= sample_value;
    end
    if (cmd.win_prep) begin
      was_full <= full_now;
    end
    if (cmd.div_init) begin
      div_q <= sum;
      div_r <= '0;
    end else if (cmd.div_step) begin
      div_q <= {div_q[SW-2:0], div_ge};
      div_r <= div_ge ? div_diff[CNT_W-1:0] : shifted[CNT_W-1:0];
    end
    if (cmd.emit) begin
      average_value <= last_average;
      overflow_hold <= hold_flag;
    end
  end

endmodule

[rtl/soca_checker.sv]
// port-level checks for the moving average core, bound to the top level
// depends on sliding_or_cumulative_average_core_defines.svh and soca_pkg
`include "sliding_or_cumulative_average_core_defines.svh"

module soca_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [soca_pkg::SAMPLE_W-1:0]  average_value,
  input logic                           overflow_hold
);

  // no result is left over from before reset
  `SOCA_ASSERT_ALWAYS(a_reset_clears_out, rst |=> !out_valid, "out_valid after reset")

  // one transaction at a time: busy right after an accept
  `SOCA_ASSERT(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall, "accept not followed by busy")

  // a new result only appears while the core is busy with its transaction
  `SOCA_ASSERT(a_result_from_busy, $rose(out_valid) |-> $past(in_stall), "result while idle")

  // stalled result holds
  `SOCA_ASSERT(a_result_holds, (out_valid && out_stall) |=> (out_valid && $stable(average_value) && $stable(overflow_hold)), "stalled result changed")

endmodule

bind sliding_or_cumulative_average_core soca_checker u_soca_checker (.*);
